// ===== hw/rtl/rgb_3x3_kernel_filter_assert.svh =====
// Assertion macros shared by the filter modules.
`ifndef RGB_3X3_KERNEL_FILTER_ASSERT_SVH
`define RGB_3X3_KERNEL_FILTER_ASSERT_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/r3kf_pkg.sv =====
// Package with types, constants and kernel arithmetic for the filter.
`timescale 1ns / 1ps
package r3kf_pkg;
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int ROW_W = 12;
  localparam int COL_W = 11;
  localparam int PX_W = 24;
  localparam int QDEPTH = 4;

  localparam logic [2:0] REG_WIDTH = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_LEFT = 3'd2;
  localparam logic [2:0] REG_RIGHT = 3'd3;
  localparam logic [2:0] REG_TOP = 3'd4;
  localparam logic [2:0] REG_BOTTOM = 3'd5;
  localparam logic [2:0] REG_MODE = 3'd6;

  localparam logic [1:0] MODE_EDGE = 2'd0;
  localparam logic [1:0] MODE_SHARPEN = 2'd1;
  localparam logic [1:0] MODE_BOX = 2'd2;
  localparam logic [1:0] MODE_GAUSS = 2'd3;

  typedef struct packed {
    logic [11:0] frame_width;
    logic [12:0] frame_height;
    logic [11:0] sel_left;
    logic [11:0] sel_right;
    logic [12:0] sel_top;
    logic [12:0] sel_bottom;
    logic [1:0]  kernel_mode;
  } cfg_t;

  typedef struct packed {
    logic            emit_win;
    logic            emit_mid;
    logic            emit_bot;
    logic            filt;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PX_W-1:0] w00, w01, w02, w10, w11, w12, w20, w21, w22;
  } job_t;

  function automatic logic [7:0] ch(input logic [PX_W-1:0] px, input int k);
    ch = px[16 - 8 * k +: 8];
  endfunction

  function automatic logic [7:0] clamp(input logic signed [12:0] v);
    if (v < 0) clamp = 8'd0;
    else if (v > 13'sd255) clamp = 8'd255;
    else clamp = v[7:0];
  endfunction
endpackage

// ===== hw/rtl/r3kf_front.sv =====
// Front end: raster position, line stores, window and result classification.
`timescale 1ns / 1ps
module r3kf_front #(
  parameter int MAX_WIDTH = r3kf_pkg::DEF_MAX_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  r3kf_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  output logic              job_valid,
  input  logic              job_ready,
  output r3kf_pkg::job_t    job
);
  import r3kf_pkg::*;
  localparam int CAPW = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
  localparam int AW = (CAPW > 1) ? $clog2(CAPW) : 1;

  logic [PX_W-1:0] upper_mem [CAPW];
  logic [PX_W-1:0] lower_mem [CAPW];

  logic [12:0] w_eff, h_eff;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] r_c;
  logic [COL_W-1:0] c_c;
  logic [12:0] col_inc;
  logic [PX_W-1:0] win_r [6];
  logic [PX_W-1:0] top_rd_r, mid_rd_r, bot_s_r;
  logic s2_valid_r;
  logic [ROW_W-1:0] s2_row_r;
  logic [COL_W-1:0] s2_col_r;
  logic [12:0] s2_w_r, s2_h_r;
  logic adv;
  logic wr_fwd;
  logic [12:0] i1, i2, j1, j2, y, x;
  logic sel;

  always_comb begin
    w_eff = (cfg.frame_width == 12'd0) ? 13'd1 : {1'b0, cfg.frame_width};
    if (w_eff > 13'(CAPW)) w_eff = 13'(CAPW);
    h_eff = (cfg.frame_height == 13'd0) ? 13'd1 : cfg.frame_height;
    if (h_eff > 13'd4096) h_eff = 13'd4096;
  end

  assign adv = !s2_valid_r || job_ready;
  assign in_ready = adv;

  always_comb begin
    if ({1'b0, row_r} >= h_eff || {2'b0, col_r} >= w_eff) begin
      r_c = '0;
      c_c = '0;
    end else begin
      r_c = row_r;
      c_c = col_r;
    end
    col_inc = {2'b0, c_c} + 13'd1;
    col_nxt = col_inc[COL_W-1:0];
    row_nxt = r_c;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = r_c + 1'b1;
      if ({1'b0, row_nxt} >= h_eff) row_nxt = '0;
    end
  end

  // A one-column frame reads the entry that the leaving request writes.
  assign wr_fwd = s2_valid_r && job_ready && (s2_col_r == c_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= in_valid;
      if (in_valid) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      if (wr_fwd) begin
        top_rd_r <= mid_rd_r;
        mid_rd_r <= bot_s_r;
      end else begin
        top_rd_r <= upper_mem[c_c[AW-1:0]];
        mid_rd_r <= lower_mem[c_c[AW-1:0]];
      end
      bot_s_r <= {in_red, in_green, in_blue};
      s2_row_r <= r_c;
      s2_col_r <= c_c;
      s2_w_r <= w_eff;
      s2_h_r <= h_eff;
    end
    if (s2_valid_r && job_ready) begin
      upper_mem[s2_col_r[AW-1:0]] <= mid_rd_r;
      lower_mem[s2_col_r[AW-1:0]] <= bot_s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (s2_valid_r && job_ready) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_rd_r;
      win_r[4] <= mid_rd_r;
      win_r[5] <= bot_s_r;
    end
  end

  always_comb begin
    y = {1'b0, s2_row_r} - 13'd1;
    x = {2'b0, s2_col_r} - 13'd1;
    i1 = cfg.sel_top + ((cfg.sel_top == 13'd0) ? 13'd1 : 13'd0);
    i2 = cfg.sel_bottom - ((cfg.sel_bottom == s2_h_r) ? 13'd1 : 13'd0);
    j1 = {1'b0, cfg.sel_left} + ((cfg.sel_left == 12'd0) ? 13'd1 : 13'd0);
    j2 = {1'b0, cfg.sel_right} - (({1'b0, cfg.sel_right} == s2_w_r) ? 13'd1 : 13'd0);
    sel = !(cfg.sel_bottom == 13'd0 || cfg.sel_right == 12'd0) &&
          (y >= 13'd1) && (x >= 13'd1) && (y + 13'd2 <= s2_h_r) &&
          (x + 13'd2 <= s2_w_r) && (y >= i1) && (y < i2) && (x >= j1) && (x < j2);
  end

  always_comb begin
    job.emit_win = (s2_row_r != '0) && (s2_col_r != '0);
    job.emit_mid = (s2_row_r != '0) && ({2'b0, s2_col_r} == s2_w_r - 13'd1);
    job.emit_bot = ({1'b0, s2_row_r} == s2_h_r - 13'd1);
    job.filt = sel;
    job.row = s2_row_r;
    job.col = s2_col_r;
    job.w00 = win_r[0]; job.w10 = win_r[1]; job.w20 = win_r[2];
    job.w01 = win_r[3]; job.w11 = win_r[4]; job.w21 = win_r[5];
    job.w02 = top_rd_r; job.w12 = mid_rd_r; job.w22 = bot_s_r;
  end
  assign job_valid = s2_valid_r;

  `include "rgb_3x3_kernel_filter_assert.svh"
  `ASSERT_NEXT(a_hold, clk, rst_n, job_valid && !job_ready, job_valid && $stable(s2_col_r))
  `ASSERT_IMPL(a_filt_inner, clk, rst_n, job_valid && job.filt, job.emit_win)
  `ASSERT_IMPL(a_col_range, clk, rst_n, job_valid, {2'b0, s2_col_r} < s2_w_r)
endmodule

// ===== hw/rtl/r3kf_queue.sv =====
// Short queue of classified requests between the front and back ends.
`timescale 1ns / 1ps
module r3kf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  r3kf_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output r3kf_pkg::job_t rd_data
);
  import r3kf_pkg::*;
  localparam int PW = $clog2(QDEPTH);
  job_t mem_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0] cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != (PW+1)'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

  `include "rgb_3x3_kernel_filter_assert.svh"
  `ASSERT_NEXT(a_cnt, clk, rst_n, wr && !rd, cnt_r == $past(cnt_r) + 1'b1)
  `ASSERT_IMPL(a_bound, clk, rst_n, 1'b1, cnt_r <= (PW+1)'(QDEPTH))
  `ASSERT_IMPL(a_empty, clk, rst_n, cnt_r == '0, wp_r == rp_r)
endmodule

// ===== hw/rtl/r3kf_back.sv =====
// Back end: kernel arithmetic and emission of up to three results a request.
`timescale 1ns / 1ps
module r3kf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        mode,
  input  logic              job_valid,
  output logic              job_ready,
  input  r3kf_pkg::job_t    job,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [11:0]       out_row,
  output logic [10:0]       out_col,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic              out_run_last
);
  import r3kf_pkg::*;
  // Stage one: registered channel sums; stage two: emission sequencer.
  logic s1_valid_r;
  job_t s1_r;
  logic signed [12:0] ed_r [3], sh_r [3];
  logic [11:0] all_r [3], ga_r [3];
  logic [2:0] pend_r, pend_nxt;
  logic [PX_W-1:0] fpx;
  logic s1_take, last_one;
  logic [2:0] pick;
  logic [7:0] bx [3];
  logic [7:0] kv [3];

  assign pend_nxt = pend_r & ~pick;
  assign last_one = pend_nxt == 3'b000;
  assign s1_take = s1_valid_r && (!out_valid || out_ready) && (pend_r == 3'b000 ? 1'b0 : last_one);
  assign job_ready = !s1_valid_r || s1_take || (s1_valid_r && pend_r == 3'b000);

  always_comb begin
    pick = 3'b000;
    if (pend_r[0]) pick = 3'b001;
    else if (pend_r[1]) pick = 3'b010;
    else if (pend_r[2]) pick = 3'b100;
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      s1_r <= job;
      for (int k = 0; k < 3; k++) begin
        all_r[k] <= 12'(ch(job.w00, k)) + 12'(ch(job.w01, k)) + 12'(ch(job.w02, k)) +
                    12'(ch(job.w10, k)) + 12'(ch(job.w11, k)) + 12'(ch(job.w12, k)) +
                    12'(ch(job.w20, k)) + 12'(ch(job.w21, k)) + 12'(ch(job.w22, k));
        ed_r[k] <= $signed({1'b0, 12'(ch(job.w11, k)) * 12'd9}) -
                   $signed({1'b0, 12'(ch(job.w00, k)) + 12'(ch(job.w01, k)) +
                   12'(ch(job.w02, k)) + 12'(ch(job.w10, k)) + 12'(ch(job.w11, k)) +
                   12'(ch(job.w12, k)) + 12'(ch(job.w20, k)) + 12'(ch(job.w21, k)) +
                   12'(ch(job.w22, k))});
        sh_r[k] <= $signed({1'b0, 12'(ch(job.w11, k)) * 12'd5}) -
                   $signed({1'b0, 12'(ch(job.w01, k)) + 12'(ch(job.w10, k)) +
                   12'(ch(job.w12, k)) + 12'(ch(job.w21, k))});
        ga_r[k] <= 12'(ch(job.w00, k)) + 12'(ch(job.w02, k)) + 12'(ch(job.w20, k)) +
                   12'(ch(job.w22, k)) + 12'(ch(job.w01, k)) * 12'd2 +
                   12'(ch(job.w10, k)) * 12'd2 + 12'(ch(job.w12, k)) * 12'd2 +
                   12'(ch(job.w21, k)) * 12'd2 + 12'(ch(job.w11, k)) * 12'd4 + 12'd8;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      // round(S/9) for S up to 2295 by reciprocal multiply.
      bx[k] = 8'((({12'b0, all_r[k]} * 24'd7282) + 24'd29127) >> 16);
      case (mode)
        MODE_EDGE: kv[k] = clamp(ed_r[k]);
        MODE_SHARPEN: kv[k] = clamp(sh_r[k]);
        MODE_BOX: kv[k] = bx[k];
        MODE_GAUSS: kv[k] = ga_r[k][11:4];
        default: kv[k] = 8'd0;
      endcase
    end
    fpx = s1_r.filt ? {kv[0], kv[1], kv[2]} : s1_r.w11;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pend_r <= 3'b000;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (s1_valid_r && pend_r != 3'b000 && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        pend_r <= pend_nxt;
      end
      if (job_valid && job_ready) begin
        s1_valid_r <= 1'b1;
        pend_r <= {job.emit_bot, job.emit_mid, job.emit_win};
      end else if (s1_take || (s1_valid_r && pend_r == 3'b000)) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && pend_r != 3'b000 && (!out_valid || out_ready)) begin
      out_run_last <= last_one;
      case (pick)
        3'b001: begin
          out_row <= s1_r.row - 1'b1;
          out_col <= s1_r.col - 1'b1;
          {out_red, out_green, out_blue} <= fpx;
        end
        3'b010: begin
          out_row <= s1_r.row - 1'b1;
          out_col <= s1_r.col;
          {out_red, out_green, out_blue} <= s1_r.w12;
        end
        default: begin
          out_row <= s1_r.row;
          out_col <= s1_r.col;
          {out_red, out_green, out_blue} <= s1_r.w22;
        end
      endcase
    end
  end

  `include "rgb_3x3_kernel_filter_assert.svh"
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_col))
  `ASSERT_IMPL(a_pick, clk, rst_n, 1'b1, $onehot0(pick))
  `ASSERT_IMPL(a_pend_valid, clk, rst_n, pend_r != 3'b000, s1_valid_r)
endmodule

// ===== hw/rtl/rgb_3x3_kernel_filter.sv =====
// Top level of the RGB 3x3 kernel filter.
// Pixels enter on in_valid/in_ready in raster order, one request each, with
// in_red, in_green and in_blue. Results leave on out_valid/out_ready with
// out_row, out_col, the three channels and out_run_last, which marks the last
// result caused by one input pixel. Each input yields zero to three results.
// A result comes out one row and one column after its input pixel; pixels of
// the last row also come out at once, and row ends add the upper pixel.
// The front end takes one pixel a cycle unless the queue is full; the back end
// emits one result a cycle while out_ready holds, so the block sustains one
// pixel a cycle except where a pixel causes two or three results, which leave
// the output port one after another.
// The line stores are one read port and one write port each; their content is
// undefined after reset and only reaches border pixels, which pass through.
// Reset clears position, window and queue state; registers go to width 1,
// height 1 and all others 0. A stalled receiver fills the output register,
// the back end, the four-entry queue and the front stage before in_ready drops.
// Registers sit at byte address 4*i on the cfg_ port; the user must write them
// only while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps
module rgb_3x3_kernel_filter #(
  parameter int MAX_WIDTH = r3kf_pkg::DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_row,
  output logic [10:0] out_col,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_run_last
);
  import r3kf_pkg::*;
  cfg_t cfg_r;
  job_t fj, qj;
  logic fv, fr, qv, qr;
  logic [2:0] idx;

  assign cfg_pready = 1'b1;
  assign idx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
      cfg_r.frame_width <= 12'd1;
      cfg_r.frame_height <= 13'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (idx)
        REG_WIDTH: cfg_r.frame_width <= cfg_pwdata[11:0];
        REG_HEIGHT: cfg_r.frame_height <= cfg_pwdata[12:0];
        REG_LEFT: cfg_r.sel_left <= cfg_pwdata[11:0];
        REG_RIGHT: cfg_r.sel_right <= cfg_pwdata[11:0];
        REG_TOP: cfg_r.sel_top <= cfg_pwdata[12:0];
        REG_BOTTOM: cfg_r.sel_bottom <= cfg_pwdata[12:0];
        REG_MODE: cfg_r.kernel_mode <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH: cfg_prdata = {20'b0, cfg_r.frame_width};
      REG_HEIGHT: cfg_prdata = {19'b0, cfg_r.frame_height};
      REG_LEFT: cfg_prdata = {20'b0, cfg_r.sel_left};
      REG_RIGHT: cfg_prdata = {20'b0, cfg_r.sel_right};
      REG_TOP: cfg_prdata = {19'b0, cfg_r.sel_top};
      REG_BOTTOM: cfg_prdata = {19'b0, cfg_r.sel_bottom};
      REG_MODE: cfg_prdata = {30'b0, cfg_r.kernel_mode};
      default: cfg_prdata = 32'b0;
    endcase
  end

  r3kf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst_n, .cfg(cfg_r), .in_valid, .in_ready, .in_red, .in_green, .in_blue,
    .job_valid(fv), .job_ready(fr), .job(fj)
  );

  r3kf_queue u_queue (
    .clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qj)
  );

  r3kf_back u_back (
    .clk, .rst_n, .mode(cfg_r.kernel_mode), .job_valid(qv), .job_ready(qr), .job(qj),
    .out_valid, .out_ready, .out_row, .out_col, .out_red, .out_green, .out_blue,
    .out_run_last
  );
endmodule
